// ===== src/vfv_pkg.sv =====
package vfv_pkg;

  localparam int COORD_W = 6;
  localparam int CFG_W   = 6;
  // one bit more than a coordinate, so that an edge of 64 and pos + 1 both fit
  localparam int EDGE_W  = COORD_W + 1;

  localparam logic [CFG_W-1:0] EDGE_RESET = 6'd16;

  typedef enum logic [1:0] {
    KIND_PLACE  = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_MASK   = 2'd3
  } kind_t;

  localparam int FACE_ZN = 0;
  localparam int FACE_ZP = 1;
  localparam int FACE_XN = 2;
  localparam int FACE_XP = 3;
  localparam int FACE_YN = 4;
  localparam int FACE_YP = 5;
  localparam int FACE_W  = 6;

endpackage

// ===== src/vfv_bank.sv =====
module vfv_bank #(
  parameter int ROW_W = 32,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [ROW_W-1:0] rdata0_r,
  output logic [ROW_W-1:0] rdata1_r
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

endmodule

// ===== src/voxel_face_visibility_top.sv =====
// Voxel occupancy store with face visibility. Blocks are held as rows along x, one row
// per (y, z), split over two single-write, dual-read banks by the parity of y + z, so a
// block's row sits in one bank and all four y/z neighbor rows sit in the other. An item
// goes through IDLE, RD2 and EXEC: the accept cycle in IDLE reads the block's row and
// both y neighbors, RD2 reads both z neighbors, and EXEC writes the row back for an
// in-range place or remove and loads the result register once it is free; a new item
// is taken only after the last leaves EXEC. After reset a fill pass sets every block
// solid, one row of each bank per cycle, over all MAX_EDGE * 2**(CW - 1) rows per
// bank (512 at MAX_EDGE = 32); in_ready stays low until then, cfg writes are taken
// throughout. chunk_edge above MAX_EDGE acts as MAX_EDGE; changing it keeps stored blocks.
module voxel_face_visibility_top #(
  parameter int MAX_EDGE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vfv_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [vfv_pkg::COORD_W-1:0]   in_pos_x,
  input  logic [vfv_pkg::COORD_W-1:0]   in_pos_y,
  input  logic [vfv_pkg::COORD_W-1:0]   in_pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_in_range,
  output logic                          out_solid,
  output logic [vfv_pkg::FACE_W-1:0]    out_face_mask
);

  localparam int CW    = (MAX_EDGE > 2) ? $clog2(MAX_EDGE) : 1;
  localparam int RA    = 2 * CW - 1;
  localparam int DEPTH = MAX_EDGE << (CW - 1);
  localparam logic [vfv_pkg::EDGE_W-1:0] MAX_E = vfv_pkg::EDGE_W'(MAX_EDGE);
  localparam logic [RA-1:0] LAST_ROW = RA'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD2,
    ST_EXEC
  } state_t;

  function automatic logic [RA-1:0] row_addr(input logic [CW-1:0] y, input logic [CW-1:0] z);
    logic [2*CW-1:0] f;
    f = {z, y};
    return f[2*CW-1:1];
  endfunction

  state_t                          state_r, state_nxt;
  logic [vfv_pkg::CFG_W-1:0]       chunk_edge_r;
  logic [RA-1:0]                   clr_cnt_r;
  vfv_pkg::kind_t                  kind_r;
  logic [vfv_pkg::COORD_W-1:0]     px_r, py_r, pz_r;
  logic                            inr_r;
  logic                            c_r;
  logic [RA-1:0]                   ctr_r;
  logic [MAX_EDGE-1:0]             hold_c_r, hold_ym_r, hold_yp_r;
  logic                            out_valid_r, out_in_range_r, out_solid_r;
  logic [vfv_pkg::FACE_W-1:0]      out_face_mask_r;

  logic [vfv_pkg::EDGE_W-1:0]      edge_eff;
  logic                            in_inr;
  logic                            accept, exec_go;
  logic [CW-1:0]                   sel_y, sel_z;
  logic                            cur_c;
  logic [RA-1:0]                   a_ctr, a_ym, a_yp, a_zm, a_zp;
  logic [RA-1:0]                   b0_ra0, b0_ra1, b1_ra0, b1_ra1, waddr;
  logic [MAX_EDGE-1:0]             b0_rd0, b0_rd1, b1_rd0, b1_rd1;
  logic [MAX_EDGE-1:0]             wdata, wrow, rzm, rzp;
  logic                            we0, we1, wr_en, here;
  logic [CW-1:0]                   xi, xm, xp;
  logic                            z_lo, z_hi, x_lo, x_hi, y_lo, y_hi;
  logic [vfv_pkg::FACE_W-1:0]      mask;

  assign edge_eff = ({1'b0, chunk_edge_r} > MAX_E) ? MAX_E : {1'b0, chunk_edge_r};
  assign in_inr   = ({1'b0, in_pos_x} < edge_eff) && ({1'b0, in_pos_y} < edge_eff) &&
                    ({1'b0, in_pos_z} < edge_eff);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // read addresses: the accept cycle uses the port payload, later cycles the held item;
  // keep reading the z neighbors while the result register is blocked
  always_comb begin
    sel_y = (state_r == ST_IDLE) ? in_pos_y[CW-1:0] : py_r[CW-1:0];
    sel_z = (state_r == ST_IDLE) ? in_pos_z[CW-1:0] : pz_r[CW-1:0];
    cur_c = sel_y[0] ^ sel_z[0];
    a_ctr = row_addr(sel_y, sel_z);
    a_ym  = row_addr(sel_y - CW'(1), sel_z);
    a_yp  = row_addr(sel_y + CW'(1), sel_z);
    a_zm  = row_addr(sel_y, sel_z - CW'(1));
    a_zp  = row_addr(sel_y, sel_z + CW'(1));
    if (state_r == ST_RD2 || state_r == ST_EXEC) begin
      b0_ra0 = a_zm;
      b0_ra1 = a_zp;
      b1_ra0 = a_zm;
      b1_ra1 = a_zp;
    end else begin
      b0_ra0 = cur_c ? a_ym : a_ctr;
      b0_ra1 = a_yp;
      b1_ra0 = cur_c ? a_ctr : a_ym;
      b1_ra1 = a_yp;
    end
  end

  always_comb begin
    xi = px_r[CW-1:0];
    xm = xi - CW'(1);
    xp = xi + CW'(1);
    case (kind_r)
      vfv_pkg::KIND_PLACE:  here = 1'b1;
      vfv_pkg::KIND_REMOVE: here = 1'b0;
      default:              here = hold_c_r[xi];
    endcase
    wr_en    = inr_r && (kind_r == vfv_pkg::KIND_PLACE || kind_r == vfv_pkg::KIND_REMOVE);
    wrow     = hold_c_r;
    wrow[xi] = here;
    rzm      = c_r ? b0_rd0 : b1_rd0;
    rzp      = c_r ? b0_rd1 : b1_rd1;
    // a neighbor outside the chunk counts as empty
    z_lo = (pz_r != '0);
    z_hi = (({1'b0, pz_r} + vfv_pkg::EDGE_W'(1)) < edge_eff);
    x_lo = (px_r != '0);
    x_hi = (({1'b0, px_r} + vfv_pkg::EDGE_W'(1)) < edge_eff);
    y_lo = (py_r != '0);
    y_hi = (({1'b0, py_r} + vfv_pkg::EDGE_W'(1)) < edge_eff);
    mask[vfv_pkg::FACE_ZN] = !(z_lo && rzm[xi]);
    mask[vfv_pkg::FACE_ZP] = !(z_hi && rzp[xi]);
    mask[vfv_pkg::FACE_XN] = !(x_lo && hold_c_r[xm]);
    mask[vfv_pkg::FACE_XP] = !(x_hi && hold_c_r[xp]);
    mask[vfv_pkg::FACE_YN] = !(y_lo && hold_ym_r[xi]);
    mask[vfv_pkg::FACE_YP] = !(y_hi && hold_yp_r[xi]);
    if (!(inr_r && here && kind_r == vfv_pkg::KIND_MASK)) begin
      mask = '0;
    end
  end

  assign we0   = (state_r == ST_CLEAR) || (exec_go && wr_en && !c_r);
  assign we1   = (state_r == ST_CLEAR) || (exec_go && wr_en && c_r);
  assign waddr = (state_r == ST_CLEAR) ? clr_cnt_r : ctr_r;
  assign wdata = (state_r == ST_CLEAR) ? '1 : wrow;

  vfv_bank #(.ROW_W(MAX_EDGE), .DEPTH(DEPTH), .AW(RA)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .raddr0(b0_ra0), .raddr1(b0_ra1), .rdata0_r(b0_rd0), .rdata1_r(b0_rd1)
  );

  vfv_bank #(.ROW_W(MAX_EDGE), .DEPTH(DEPTH), .AW(RA)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .raddr0(b1_ra0), .raddr1(b1_ra1), .rdata0_r(b1_rd0), .rdata1_r(b1_rd1)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_ROW) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      chunk_edge_r <= vfv_pkg::EDGE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + RA'(1);
      end
      if (cfg_we) begin
        chunk_edge_r <= cfg_wdata;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload: hold the item and the first read phase
    if (accept) begin
      kind_r <= vfv_pkg::kind_t'(in_kind);
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
      inr_r  <= in_inr;
      c_r    <= cur_c;
      ctr_r  <= a_ctr;
    end
    if (state_r == ST_RD2) begin
      hold_c_r  <= c_r ? b1_rd0 : b0_rd0;
      hold_ym_r <= c_r ? b0_rd0 : b1_rd0;
      hold_yp_r <= c_r ? b0_rd1 : b1_rd1;
    end
    if (exec_go) begin
      out_in_range_r  <= inr_r;
      out_solid_r     <= inr_r && here;
      out_face_mask_r <= mask;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_in_range  = out_in_range_r;
  assign out_solid     = out_solid_r;
  assign out_face_mask = out_face_mask_r;

endmodule

// ===== src/vfv_checker.sv =====
module vfv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_in_range,
  input logic                        out_solid,
  input logic [vfv_pkg::FACE_W-1:0]  out_face_mask
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_solid) &&
    $stable(out_in_range) && $stable(out_face_mask))
    else $error("result changed while stalled");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> !out_solid && out_face_mask == '0)
    else $error("out-of-range item reports solid or faces");

  a_face_solid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_face_mask != '0 |-> out_solid && out_in_range)
    else $error("faces reported for an empty block");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

bind voxel_face_visibility_top vfv_checker u_vfv_checker (.*);
